@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked on clk, suspended while arst_n is low
`define BRCV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on clk, also during reset
`define BRCV_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BRCV_ASSERT(lbl, prop, msg)
`define BRCV_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ sv/brcv_pkg.sv @@
// Package for the repeat consensus vote block: sizes, codes, types and helpers.
package brcv_pkg;

	localparam int MAX_REPEAT  = 63;
	localparam int COUNT_WIDTH = 16;
	localparam int NUM_BASES   = 4;
	localparam int NUM_SYMBOLS = 5;
	localparam int HIST_ROW    = MAX_REPEAT + 1;
	localparam int HIST_DEPTH  = NUM_BASES * HIST_ROW;
	localparam int HIST_AW     = $clog2(HIST_DEPTH);

	localparam int ACTION_W = 1;
	localparam int SYM_W    = 3;
	localparam int REP_W    = 6;
	localparam int BIDX_W   = $clog2(NUM_BASES);
	localparam int SIDX_W   = $clog2(NUM_SYMBOLS);

	localparam logic [ACTION_W-1:0] ACT_RECORD = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_QUERY  = 1'b1;
	localparam logic [SYM_W-1:0]    SYM_GAP    = 3'd4;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [REP_W-1:0]       rep_t;
	typedef logic [SYM_W-1:0]       sym_t;

	// state update from the compute stage to the tally registers
	typedef struct packed {
		logic   en;
		logic   tot_en;
		logic   base_en;
		sym_t   sym;
		count_t tot;
		rep_t   best;
		rep_t   high;
	} brcv_tally_wr_t;

	// current tallies of one symbol
	typedef struct packed {
		count_t tot;
		rep_t   best;
		rep_t   high;
	} brcv_view_t;

	// overall leader
	typedef struct packed {
		sym_t   sym;
		count_t tot;
		rep_t   rep;
	} brcv_lead_t;

	function automatic count_t sat_inc(input count_t v);
		return (v == '1) ? v : count_t'(v + count_t'(1));
	endfunction

	function automatic rep_t clamp_rep(input rep_t r);
		return (int'(r) > MAX_REPEAT) ? rep_t'(MAX_REPEAT) : r;
	endfunction

endpackage

@@ sv/brcv_if.sv @@
// Handshake interfaces for vote items and result items.
interface brcv_in_if import brcv_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	sym_t                base;
	rep_t                repeat_count;

	modport source(output valid, action, base, repeat_count, input ready);
	modport sink(input valid, action, base, repeat_count, output ready);
endinterface

interface brcv_out_if import brcv_pkg::*; ();
	logic   valid;
	logic   ready;
	count_t base_total;
	count_t repeat_total;
	rep_t   best_repeat;
	rep_t   highest_repeat;
	sym_t   best_symbol;
	count_t best_symbol_total;
	rep_t   best_symbol_repeat;

	modport source(output valid, base_total, repeat_total, best_repeat, highest_repeat,
		best_symbol, best_symbol_total, best_symbol_repeat, input ready);
	modport sink(input valid, base_total, repeat_total, best_repeat, highest_repeat,
		best_symbol, best_symbol_total, best_symbol_repeat, output ready);
endinterface

@@ sv/base_repeat_consensus_vote.sv @@
// Top level of the repeat consensus vote block for one aligned column.
//
//  channel | dir | payload                                           | handshake
//  --------+-----+---------------------------------------------------+-------------
//  vote    | in  | action, base, repeat_count                        | valid/ready
//  result  | out | base_total, repeat_total, best_repeat,            | valid/ready
//          |     | highest_repeat, best_symbol, best_symbol_total,   |
//          |     | best_symbol_repeat                                |
//
// An item goes through the histogram read (registered memory output), read-modify-write
// of the histogram and tally registers, then leader selection into the result register.
// The next item is taken once the previous one has reached the result register, so only
// one item is in flight at a time.
// Reset clears the tallies at once; the histogram reads as zero through per-entry valid bits,
// so no clearing pass is needed.
// A stalled result holds the item in result staging; vote.ready stays low until it drains.
`include "assert_macros.svh"

module base_repeat_consensus_vote import brcv_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	brcv_in_if.sink    vote,
	brcv_out_if.source result
);

	logic accept;

	// read stage
	logic               s1_v_q;
	logic [ACTION_W-1:0] action_s1;
	sym_t               sym_s1;
	rep_t               rep_s1;
	rep_t               cur_best_s1;
	logic [HIST_AW-1:0] addr_s1;

	// result staging
	logic   s2_v_q;
	count_t base_total_s2;
	count_t repeat_total_s2;
	rep_t   best_repeat_s2;
	rep_t   highest_repeat_s2;

	// result register
	logic   out_v_q;
	count_t base_total_q;
	count_t repeat_total_q;
	rep_t   best_repeat_q;
	rep_t   highest_repeat_q;
	sym_t   best_symbol_q;
	count_t best_symbol_total_q;
	rep_t   best_symbol_repeat_q;

	rep_t               rep_in;
	rep_t               look_best;
	logic [HIST_AW-1:0] addr_a, addr_b;
	count_t             hist_a, hist_b;

	brcv_view_t     view;
	brcv_lead_t     lead;
	brcv_tally_wr_t tally_wr;

	logic   is_base, is_gap, vote_base, vote_gap, set_best, load_out;
	count_t hist_new, tot_new;
	rep_t   best_new, high_new;

	assign vote.ready = !s1_v_q && !s2_v_q;
	assign accept     = vote.valid && vote.ready;

	// histogram addresses: the voted entry and the entry of the current best repeat
	assign rep_in = clamp_rep(vote.repeat_count);
	assign addr_a = HIST_AW'(HIST_AW'(vote.base[BIDX_W-1:0]) * HIST_AW'(HIST_ROW))
		+ HIST_AW'(rep_in);
	assign addr_b = HIST_AW'(HIST_AW'(vote.base[BIDX_W-1:0]) * HIST_AW'(HIST_ROW))
		+ HIST_AW'(look_best);

	brcv_hist_mem u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr_a (addr_a),
		.rd_addr_b (addr_b),
		.rd_data_a (hist_a),
		.rd_data_b (hist_b),
		.wr_en     (s1_v_q && vote_base),
		.wr_addr   (addr_s1),
		.wr_data   (hist_new)
	);

	brcv_tally u_tally (
		.clk       (clk),
		.arst_n    (arst_n),
		.look_sym  (vote.base),
		.look_best (look_best),
		.view_sym  (sym_s1),
		.view      (view),
		.wr        (tally_wr),
		.lead      (lead)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1   <= vote.action;
			sym_s1      <= vote.base;
			rep_s1      <= rep_in;
			cur_best_s1 <= look_best;
			addr_s1     <= addr_a;
		end
	end

	// modify: one only item in flight, so the write lands before the next read
	always_comb begin
		is_base   = int'(sym_s1) < NUM_BASES;
		is_gap    = sym_s1 == SYM_GAP;
		vote_base = (action_s1 == ACT_RECORD) && is_base;
		vote_gap  = (action_s1 == ACT_RECORD) && is_gap;
		hist_new  = sat_inc(hist_a);
		tot_new   = (vote_base || vote_gap) ? sat_inc(view.tot) : view.tot;
		// voting the best repeat itself never moves it
		set_best  = vote_base && (cur_best_s1 != rep_s1)
			&& ((hist_new > hist_b) || ((hist_new == hist_b) && (rep_s1 < cur_best_s1)));
		best_new  = set_best ? rep_s1 : view.best;
		high_new  = (vote_base && (rep_s1 > view.high)) ? rep_s1 : view.high;

		tally_wr.en      = s1_v_q;
		tally_wr.tot_en  = vote_base || vote_gap;
		tally_wr.base_en = vote_base;
		tally_wr.sym     = sym_s1;
		tally_wr.tot     = tot_new;
		tally_wr.best    = best_new;
		tally_wr.high    = high_new;
	end

	always_ff @(posedge clk) begin
		if (s1_v_q) begin
			base_total_s2     <= (is_base || is_gap) ? tot_new : '0;
			repeat_total_s2   <= is_base ? (vote_base ? hist_new : hist_a) : '0;
			best_repeat_s2    <= is_base ? best_new : '0;
			highest_repeat_s2 <= is_base ? high_new : '0;
		end
	end

	// leader is taken from the tallies after this item's update
	assign load_out = s2_v_q && (!out_v_q || result.ready);

	always_ff @(posedge clk) begin
		if (load_out) begin
			base_total_q         <= base_total_s2;
			repeat_total_q       <= repeat_total_s2;
			best_repeat_q        <= best_repeat_s2;
			highest_repeat_q     <= highest_repeat_s2;
			best_symbol_q        <= lead.sym;
			best_symbol_total_q  <= lead.tot;
			best_symbol_repeat_q <= lead.rep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			s1_v_q <= accept;
			if (s1_v_q) begin
				s2_v_q <= 1'b1;
			end else if (load_out) begin
				s2_v_q <= 1'b0;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign result.valid              = out_v_q;
	assign result.base_total         = base_total_q;
	assign result.repeat_total       = repeat_total_q;
	assign result.best_repeat        = best_repeat_q;
	assign result.highest_repeat     = highest_repeat_q;
	assign result.best_symbol        = best_symbol_q;
	assign result.best_symbol_total  = best_symbol_total_q;
	assign result.best_symbol_repeat = best_symbol_repeat_q;

	`BRCV_ASSERT(a_single_item, !(s1_v_q && s2_v_q), "two items in flight")
	`BRCV_ASSERT(a_s1_advances, s1_v_q |=> (!s1_v_q && s2_v_q), "read stage did not advance")
	`BRCV_ASSERT(a_load_sets_valid, load_out |=> (result.valid && !s2_v_q),
		"result not presented after load")
	`BRCV_ASSERT_RST(a_reset_quiet, !arst_n |-> (!result.valid && vote.ready),
		"not idle in reset")

endmodule

@@ sv/brcv_hist_mem.sv @@
// Repeat-count histogram: two registered read ports, one write port, valid bit per entry.
module brcv_hist_mem import brcv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [HIST_AW-1:0] rd_addr_a,
	input  logic [HIST_AW-1:0] rd_addr_b,
	output count_t             rd_data_a,
	output count_t             rd_data_b,
	input  logic               wr_en,
	input  logic [HIST_AW-1:0] wr_addr,
	input  count_t             wr_data
);

	count_t                mem [HIST_DEPTH];
	logic [HIST_DEPTH-1:0] vld_q;
	count_t                data_a_q, data_b_q;
	logic                  vld_a_q, vld_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_a_q <= mem[rd_addr_a];
			data_b_q <= mem[rd_addr_b];
		end
	end

	// never-written entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_a_q <= vld_q[rd_addr_a];
				vld_b_q <= vld_q[rd_addr_b];
			end
		end
	end

	assign rd_data_a = vld_a_q ? data_a_q : '0;
	assign rd_data_b = vld_b_q ? data_b_q : '0;

endmodule

@@ sv/brcv_tally.sv @@
// Per-symbol totals, per-base best and highest repeat, and the overall leader.
module brcv_tally import brcv_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  sym_t           look_sym,
	output rep_t           look_best,
	input  sym_t           view_sym,
	output brcv_view_t     view,
	input  brcv_tally_wr_t wr,
	output brcv_lead_t     lead
);

	count_t totals_q [NUM_SYMBOLS];
	rep_t   best_q   [NUM_BASES];
	rep_t   high_q   [NUM_BASES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SYMBOLS; i++) begin
				totals_q[i] <= '0;
			end
			for (int i = 0; i < NUM_BASES; i++) begin
				best_q[i] <= '0;
				high_q[i] <= '0;
			end
		end else if (wr.en) begin
			if (wr.tot_en) begin
				totals_q[wr.sym[SIDX_W-1:0]] <= wr.tot;
			end
			if (wr.base_en) begin
				best_q[wr.sym[BIDX_W-1:0]] <= wr.best;
				high_q[wr.sym[BIDX_W-1:0]] <= wr.high;
			end
		end
	end

	assign look_best = best_q[look_sym[BIDX_W-1:0]];

	always_comb begin
		view.tot  = (int'(view_sym) < NUM_SYMBOLS) ? totals_q[view_sym[SIDX_W-1:0]] : '0;
		view.best = (int'(view_sym) < NUM_BASES) ? best_q[view_sym[BIDX_W-1:0]] : '0;
		view.high = (int'(view_sym) < NUM_BASES) ? high_q[view_sym[BIDX_W-1:0]] : '0;
	end

	// strict greater-than keeps the lowest index on a tie
	always_comb begin
		lead.sym = '0;
		lead.tot = totals_q[0];
		for (int i = 1; i < NUM_SYMBOLS; i++) begin
			if (totals_q[i] > lead.tot) begin
				lead.tot = totals_q[i];
				lead.sym = sym_t'(i);
			end
		end
		lead.rep = (int'(lead.sym) < NUM_BASES) ? best_q[lead.sym[BIDX_W-1:0]] : '0;
	end

endmodule
